@@ sv/frrr_pkg.sv @@
// ----------------------------------------------------------------------------
// frrr_pkg
// shared types and constants of the frame rate resolution regulator
// ----------------------------------------------------------------------------
`default_nettype none
package frrr_pkg;
  localparam int unsigned RateW  = 20;
  localparam int unsigned ScaleW = 17;
  localparam int unsigned SizeW  = 14;
  localparam int unsigned DivW   = 32;

  localparam logic [2:0] RegPolicy  = 3'd0;
  localparam logic [2:0] RegGoal    = 3'd1;
  localparam logic [2:0] RegLowest  = 3'd2;
  localparam logic [2:0] RegHighest = 3'd3;
  localparam logic [2:0] RegDelay   = 3'd4;
  localparam logic [2:0] RegGain    = 3'd5;
  localparam logic [2:0] RegWidth   = 3'd6;
  localparam logic [2:0] RegHeight  = 3'd7;

  localparam logic [1:0] PolOff = 2'd0;

  localparam logic [RateW-1:0] RateMax     = 20'hFFFFF;
  localparam logic [RateW-1:0] RateDefault = 20'd15360;
  localparam logic [DivW-1:0]  RateNumer   = 32'd65536000;

  typedef struct packed {
    logic           start;
    logic [DivW-1:0] numer;
    logic [DivW-1:0] denom;
  } div_req_t;

  // thresholds in hundredths
  function automatic logic [6:0] pol_th(input logic [1:0] p, input logic [1:0] k);
    logic [6:0] r;
    r = 7'd0;
    case (p)
      2'd1: r = (k == 2'd0) ? 7'd90 : (k == 2'd1) ? 7'd95 : 7'd100;
      2'd2: r = (k == 2'd0) ? 7'd85 : (k == 2'd1) ? 7'd92 : 7'd98;
      2'd3: r = (k == 2'd0) ? 7'd75 : (k == 2'd1) ? 7'd85 : 7'd95;
      default: r = 7'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [14:0] pol_st(input logic [1:0] p, input logic [1:0] k);
    logic signed [14:0] r;
    r = '0;
    case (p)
      2'd1: r = (k == 2'd0) ? -15'sd9830 : (k == 2'd1) ? -15'sd5243 : 15'sd1311;
      2'd2: r = (k == 2'd0) ? -15'sd6554 : (k == 2'd1) ? -15'sd3277 : 15'sd1966;
      2'd3: r = (k == 2'd0) ? -15'sd5243 : (k == 2'd1) ? -15'sd1966 : 15'sd3277;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

@@ sv/frrr_div.sv @@
// ----------------------------------------------------------------------------
// frrr_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module frrr_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire frrr_pkg::div_req_t req_i,
  output logic                   done_o,
  output logic [frrr_pkg::DivW-1:0] quot_o
);
  import frrr_pkg::*;

  logic [DivW-1:0] quot_q, quot_d, den_q, den_d;
  logic [DivW:0]   rem_q, rem_d, trial;
  logic [5:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;

  assign trial = {rem_q[DivW-1:0], quot_q[DivW-1]} - {1'b0, den_q};

  always_comb begin
    quot_d = quot_q; den_d = den_q; rem_d = rem_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    if (req_i.start) begin
      quot_d = req_i.numer; den_d = req_i.denom; rem_d = '0;
      cnt_d = 6'(DivW); busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DivW]) begin
        rem_d = trial;
        quot_d = {quot_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DivW-1:0], quot_q[DivW-1]};
        quot_d = {quot_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d; den_q <= den_d; rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule
`default_nettype wire

@@ sv/frame_rate_resolution_regulator_unit.sv @@
// ----------------------------------------------------------------------------
// frame_rate_resolution_regulator_unit
// dynamic resolution scaling from frame periods
// ----------------------------------------------------------------------------
// an input transaction runs the rate division in the shared divider, then the
// window update, the mean division and the scale steps; when disabled, only
// the rate division. The next input transaction is accepted once the result is
// registered for output, later while a finished result waits for m_axis_tready
// reset: asynchronous active low, control and configuration registers take their
// defaults; the window memory needs no clearing, only filled entries are read
`default_nettype none
module frame_rate_resolution_regulator_unit #(
  parameter int unsigned WINDOW_DEPTH = 60
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [16:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // frame_period[17:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // applied_scale[16:0] frame_rate[36:17] mean_rate[56:37] scaled_width[70:57]
  // scaled_height[84:71] shrinking[85] change_tally[117:86]
  output logic [119:0]     m_axis_tdata
);
  import frrr_pkg::*;

  localparam int unsigned AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned FW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned TW = RateW + FW;
  localparam logic [FW-1:0] FillFull = FW'(WINDOW_DEPTH);
  localparam logic [AW-1:0] SlotLast = AW'(WINDOW_DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RDIV, S_RWAIT, S_WIN, S_MEAN, S_MWAIT, S_STEP, S_DIFF, S_LIVE,
    S_SIZE, S_OUT
  } state_e;

  state_e state_q;
  logic [1:0]  pol_q;
  logic [7:0]  goal_q, dly_q;
  logic [16:0] low_q, high_q, gain_q;
  logic [13:0] fw_q, fh_q;
  logic [17:0] per_q;
  logic [RateW-1:0] rate_q, mean_q, old_q;
  logic [RateW-1:0] win_mem [WINDOW_DEPTH];
  logic [FW-1:0] fill_q;
  logic [AW-1:0] slot_q;
  logic [TW-1:0] total_q;
  logic signed [18:0] aim_q, live_q;
  logic [ScaleW-1:0] rep_q;
  logic [7:0]  pend_q;
  logic        head_q, down_q;
  logic [31:0] tally_q;
  logic signed [36:0] prod_q;
  logic [30:0] wprod_q, hprod_q;
  logic [119:0] out_q;
  div_req_t div_req;
  logic div_done;
  logic [DivW-1:0] div_quot;

  frrr_div u_div (.clk_i, .rst_ni, .req_i(div_req), .done_o(div_done), .quot_o(div_quot));

  // step selection
  logic [26:0] lhs, goal256;
  logic [33:0] tha, thb, thc;
  logic signed [14:0] step_raw;
  always_comb begin
    lhs = 27'(mean_q) * 27'd100;
    goal256 = {11'd0, goal_q, 8'd0};
    tha = 34'(pol_th(pol_q, 2'd0)) * 34'(goal256);
    thb = 34'(pol_th(pol_q, 2'd1)) * 34'(goal256);
    thc = 34'(pol_th(pol_q, 2'd2)) * 34'(goal256);
    if (34'(lhs) < tha) step_raw = pol_st(pol_q, 2'd0);
    else if (34'(lhs) < thb) step_raw = pol_st(pol_q, 2'd1);
    else if (34'(lhs) > thc) step_raw = pol_st(pol_q, 2'd2);
    else step_raw = '0;
  end

  // direction hysteresis and target clamp
  logic signed [19:0] aim_t;
  logic [7:0] pinc;
  logic step_dn, step_take;
  always_comb begin
    step_dn = step_raw < 0;
    pinc = pend_q + 8'd1;
    step_take = (step_dn == head_q) || (pinc >= dly_q);
    aim_t = 20'(aim_q);
    if (step_take) aim_t = aim_t + 20'(step_raw);
    if (aim_t < $signed({3'd0, low_q})) aim_t = $signed({3'd0, low_q});
    if (aim_t > $signed({3'd0, high_q})) aim_t = $signed({3'd0, high_q});
  end

  logic signed [36:0] delta;
  logic signed [19:0] live_n;
  logic signed [19:0] rdiff;
  always_comb begin
    if (prod_q >= 0) delta = prod_q >>> 16;
    else delta = -((-prod_q + 37'sd65535) >>> 16);
    live_n = 20'(live_q) + 20'(delta);
    rdiff = 20'(live_q) - $signed({3'd0, rep_q});
  end

  always_comb begin
    div_req.start = (state_q == S_RDIV) || (state_q == S_MEAN);
    div_req.numer = (state_q == S_RDIV) ? RateNumer : DivW'(total_q);
    div_req.denom = (state_q == S_RDIV) ? DivW'(per_q) : DivW'(fill_q);
  end

  always_ff @(posedge clk_i) begin
    old_q <= win_mem[slot_q];
    if (state_q == S_WIN) win_mem[slot_q] <= rate_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pol_q <= 2'd0; goal_q <= 8'd60; low_q <= 17'd32768; high_q <= 17'd65536;
      dly_q <= 8'd5; gain_q <= 17'd6554; fw_q <= 14'd1920; fh_q <= 14'd1080;
      fill_q <= '0; slot_q <= '0; total_q <= '0;
      aim_q <= 19'sd65536; live_q <= 19'sd65536; pend_q <= '0; head_q <= 1'b0;
      rep_q <= 17'd65536; tally_q <= '0; m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state_q != S_OUT)) m_axis_tvalid <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegPolicy:  pol_q  <= cfg_wdata_i[1:0];
          RegGoal:    goal_q <= cfg_wdata_i[7:0];
          RegLowest:  low_q  <= cfg_wdata_i;
          RegHighest: high_q <= cfg_wdata_i;
          RegDelay:   dly_q  <= cfg_wdata_i[7:0];
          RegGain:    gain_q <= cfg_wdata_i;
          RegWidth:   fw_q   <= cfg_wdata_i[13:0];
          RegHeight:  fh_q   <= cfg_wdata_i[13:0];
          default:    ;
        endcase
        fill_q <= '0; slot_q <= '0; total_q <= '0; pend_q <= '0; head_q <= 1'b0;
        tally_q <= '0;
        aim_q <= (cfg_idx_i == RegHighest) ? $signed({2'd0, cfg_wdata_i})
                                           : $signed({2'd0, high_q});
        live_q <= (cfg_idx_i == RegHighest) ? $signed({2'd0, cfg_wdata_i})
                                            : $signed({2'd0, high_q});
      end
      unique case (state_q)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          per_q <= s_axis_tdata[17:0];
          state_q <= S_RDIV;
        end
        S_RDIV: state_q <= S_RWAIT;
        S_RWAIT: if (div_done) begin
          if (per_q == '0) rate_q <= RateDefault;
          else if (div_quot > DivW'(RateMax)) rate_q <= RateMax;
          else rate_q <= div_quot[RateW-1:0];
          state_q <= S_WIN;
        end
        S_WIN: begin
          if (pol_q == PolOff) begin
            out_q <= {2'd0, tally_q, 1'b0, fh_q, fw_q, {RateW{1'b0}}, rate_q,
                      17'd65536};
            state_q <= S_OUT;
          end else begin
            if (fill_q >= FillFull) total_q <= total_q - TW'(old_q) + TW'(rate_q);
            else begin
              total_q <= total_q + TW'(rate_q);
              fill_q <= fill_q + 1'b1;
            end
            slot_q <= (slot_q == SlotLast) ? '0 : slot_q + 1'b1;
            state_q <= S_MEAN;
          end
        end
        S_MEAN: state_q <= S_MWAIT;
        S_MWAIT: if (div_done) begin
          mean_q <= div_quot[RateW-1:0];
          state_q <= S_STEP;
        end
        S_STEP: begin
          down_q <= step_dn;
          if (step_dn != head_q) begin
            if (pinc < dly_q) pend_q <= pinc;
            else begin
              head_q <= step_dn; pend_q <= '0;
            end
          end else begin
            pend_q <= '0;
          end
          aim_q <= 19'(aim_t);
          state_q <= S_DIFF;
        end
        S_DIFF: begin
          prod_q <= 37'(aim_q - live_q) * $signed({20'd0, gain_q});
          state_q <= S_LIVE;
        end
        S_LIVE: begin
          if (live_n < 0) live_q <= '0;
          else if (live_n > 20'sd131071) live_q <= 19'sd131071;
          else live_q <= 19'(live_n);
          state_q <= S_SIZE;
        end
        S_SIZE: begin
          wprod_q <= 31'(fw_q) * 31'(live_q[16:0]);
          hprod_q <= 31'(fh_q) * 31'(live_q[16:0]);
          if (rdiff > 20'sd3276 || rdiff < -20'sd3276) begin
            tally_q <= tally_q + 32'd1;
            rep_q <= live_q[16:0];
          end
          state_q <= S_OUT;
        end
        S_OUT: if (!m_axis_tvalid || m_axis_tready) begin
          if (pol_q == PolOff) m_axis_tdata <= out_q;
          else m_axis_tdata <= {2'd0, tally_q, down_q,
            (hprod_q[30:16] > 15'd16383) ? 14'd16383 : hprod_q[29:16],
            (wprod_q[30:16] > 15'd16383) ? 14'd16383 : wprod_q[29:16],
            mean_q, rate_q, live_q[16:0]};
          m_axis_tvalid <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);

  a_div_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_RWAIT || state_q == S_MWAIT)) else $error("div done");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillFull) else $error("fill");
  a_ready_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |=> (m_axis_tvalid || state_q == S_OUT)) else $error("out");
endmodule
`default_nettype wire
